// ===== rtl/spi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_pkg
// shared widths, codes and payload types of the segment/plane intersector
// ----------------------------------------------------------------------------
package spi_pkg;

  localparam int CoordW = 32;
  localparam int FracW  = 16;
  localparam int UW     = FracW + 1;
  localparam int DiffW  = CoordW + 1;
  localparam int ProdW  = CoordW + DiffW;
  localparam int DotW   = ProdW + 2;
  localparam int NumRegs = 6;
  localparam int IdxW   = 3;

  typedef enum logic [1:0] {
    ST_HIT      = 2'd0,
    ST_PARALLEL = 2'd1,
    ST_MISS     = 2'd2
  } status_e;

  typedef enum logic [IdxW-1:0] {
    REG_PX = 3'd0,
    REG_PY = 3'd1,
    REG_PZ = 3'd2,
    REG_NX = 3'd3,
    REG_NY = 3'd4,
    REG_NZ = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic signed [CoordW-1:0] seg_start_x;
    logic signed [CoordW-1:0] seg_start_y;
    logic signed [CoordW-1:0] seg_start_z;
    logic signed [CoordW-1:0] seg_end_x;
    logic signed [CoordW-1:0] seg_end_y;
    logic signed [CoordW-1:0] seg_end_z;
  } seg_t;

  typedef struct packed {
    status_e                  status;
    logic [UW-1:0]            param_u;
    logic signed [CoordW-1:0] hit_x;
    logic signed [CoordW-1:0] hit_y;
    logic signed [CoordW-1:0] hit_z;
  } res_t;

  typedef struct packed {
    logic signed [CoordW-1:0] px;
    logic signed [CoordW-1:0] py;
    logic signed [CoordW-1:0] pz;
    logic signed [CoordW-1:0] nx;
    logic signed [CoordW-1:0] ny;
    logic signed [CoordW-1:0] nz;
  } plane_t;

  // stage control type with advance and valid flags
  typedef struct packed {
    logic adv;
    logic vld;
  } stage_ctl_t;

endpackage

// ===== rtl/spi_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_stream_if
// valid/ready channel with a generic payload
// ----------------------------------------------------------------------------
interface spi_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/spi_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_front
// differences, dot products and classification, three register stages
// ----------------------------------------------------------------------------
module spi_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            adv_i,
  input  logic                            vld_i,
  input  spi_pkg::seg_t                   seg_i,
  input  spi_pkg::plane_t                 plane_i,
  output logic                            vld_o,
  output logic                            hit_o,
  output spi_pkg::status_e                status_o,
  output logic [spi_pkg::DotW-1:0]        anw_o,
  output logic [spi_pkg::DotW-1:0]        and_o,
  output logic signed [spi_pkg::CoordW-1:0] sx_o, sy_o, sz_o,
  output logic signed [spi_pkg::DiffW-1:0]  dx_o, dy_o, dz_o
);
  localparam int DW = spi_pkg::DiffW;
  localparam int PW = spi_pkg::ProdW;
  localparam int TW = spi_pkg::DotW;
  localparam int CW = spi_pkg::CoordW;

  // stage 1: differences
  logic v1_q, v2_q, v3_q;
  logic signed [CW-1:0] s1x_q, s1y_q, s1z_q, s2x_q, s2y_q, s2z_q;
  logic signed [DW-1:0] d1x_q, d1y_q, d1z_q, w1x_q, w1y_q, w1z_q;
  logic signed [DW-1:0] d2x_q, d2y_q, d2z_q;
  logic signed [PW-1:0] pdx_q, pdy_q, pdz_q, pwx_q, pwy_q, pwz_q;
  logic signed [TW-1:0] nd_d, nw_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= vld_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1x_q <= seg_i.seg_start_x;
      s1y_q <= seg_i.seg_start_y;
      s1z_q <= seg_i.seg_start_z;
      d1x_q <= DW'(seg_i.seg_end_x) - DW'(seg_i.seg_start_x);
      d1y_q <= DW'(seg_i.seg_end_y) - DW'(seg_i.seg_start_y);
      d1z_q <= DW'(seg_i.seg_end_z) - DW'(seg_i.seg_start_z);
      w1x_q <= DW'(plane_i.px) - DW'(seg_i.seg_start_x);
      w1y_q <= DW'(plane_i.py) - DW'(seg_i.seg_start_y);
      w1z_q <= DW'(plane_i.pz) - DW'(seg_i.seg_start_z);
      // stage 2: products
      s2x_q <= s1x_q;
      s2y_q <= s1y_q;
      s2z_q <= s1z_q;
      d2x_q <= d1x_q;
      d2y_q <= d1y_q;
      d2z_q <= d1z_q;
      pdx_q <= PW'(plane_i.nx) * PW'(d1x_q);
      pdy_q <= PW'(plane_i.ny) * PW'(d1y_q);
      pdz_q <= PW'(plane_i.nz) * PW'(d1z_q);
      pwx_q <= PW'(plane_i.nx) * PW'(w1x_q);
      pwy_q <= PW'(plane_i.ny) * PW'(w1y_q);
      pwz_q <= PW'(plane_i.nz) * PW'(w1z_q);
      // stage 3: sums and classification
      sx_o <= s2x_q;
      sy_o <= s2y_q;
      sz_o <= s2z_q;
      dx_o <= d2x_q;
      dy_o <= d2y_q;
      dz_o <= d2z_q;
      anw_o <= nw_d[TW-1] ? -nw_d : nw_d;
      and_o <= nd_d[TW-1] ? -nd_d : nd_d;
      // with equal signs the magnitude test is a plain signed compare
      if (nd_d == '0) begin
        status_o <= spi_pkg::ST_PARALLEL;
        hit_o    <= 1'b0;
      end else if ((nw_d != '0 && nw_d[TW-1] != nd_d[TW-1]) ||
                   (nd_d[TW-1] ? (nw_d < nd_d) : (nw_d > nd_d))) begin
        status_o <= spi_pkg::ST_MISS;
        hit_o    <= 1'b0;
      end else begin
        status_o <= spi_pkg::ST_HIT;
        hit_o    <= 1'b1;
      end
    end
  end

  // dot product sums
  assign nd_d = TW'(pdx_q) + TW'(pdy_q) + TW'(pdz_q);
  assign nw_d = TW'(pwx_q) + TW'(pwy_q) + TW'(pwz_q);
  assign vld_o = v3_q;
endmodule

// ===== rtl/spi_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_divider
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module spi_divider (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              adv_i,
  input  logic                              vld_i,
  input  logic                              hit_i,
  input  spi_pkg::status_e                  status_i,
  input  logic [spi_pkg::DotW-1:0]          anw_i,
  input  logic [spi_pkg::DotW-1:0]          and_i,
  input  logic signed [spi_pkg::CoordW-1:0] sx_i, sy_i, sz_i,
  input  logic signed [spi_pkg::DiffW-1:0]  dx_i, dy_i, dz_i,
  output logic                              vld_o,
  output logic                              hit_o,
  output spi_pkg::status_e                  status_o,
  output logic [spi_pkg::UW-1:0]            u_o,
  output logic signed [spi_pkg::CoordW-1:0] sx_o, sy_o, sz_o,
  output logic signed [spi_pkg::DiffW-1:0]  dx_o, dy_o, dz_o
);
  localparam int NS = spi_pkg::UW;
  localparam int TW = spi_pkg::DotW + 1;
  localparam int UW = spi_pkg::UW;

  logic [NS-1:0]         v_q, h_q;
  spi_pkg::status_e      st_q [NS];
  logic [TW-1:0]         r_q  [NS];
  logic [TW-1:0]         dv_q [NS];
  logic [UW-1:0]         u_q  [NS];
  logic signed [spi_pkg::CoordW-1:0] sx_q [NS], sy_q [NS], sz_q [NS];
  logic signed [spi_pkg::DiffW-1:0]  dx_q [NS], dy_q [NS], dz_q [NS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[NS-2:0], vld_i};
    end
  end

  // one stage per quotient bit; the first stage takes the integer bit
  always_ff @(posedge clk_i) begin
    logic [TW-1:0] rin;
    logic [TW-1:0] din;
    logic [UW-1:0] uin;
    if (adv_i) begin
      for (int k = 0; k < NS; k++) begin
        if (k == 0) begin
          rin = TW'(anw_i);
          din = TW'(and_i);
          uin = '0;
          h_q[k]  <= hit_i;
          st_q[k] <= status_i;
          sx_q[k] <= sx_i; sy_q[k] <= sy_i; sz_q[k] <= sz_i;
          dx_q[k] <= dx_i; dy_q[k] <= dy_i; dz_q[k] <= dz_i;
        end else begin
          rin = r_q[k-1] << 1;
          din = dv_q[k-1];
          uin = u_q[k-1] << 1;
          h_q[k]  <= h_q[k-1];
          st_q[k] <= st_q[k-1];
          sx_q[k] <= sx_q[k-1]; sy_q[k] <= sy_q[k-1]; sz_q[k] <= sz_q[k-1];
          dx_q[k] <= dx_q[k-1]; dy_q[k] <= dy_q[k-1]; dz_q[k] <= dz_q[k-1];
        end
        dv_q[k] <= din;
        if (rin >= din) begin
          r_q[k] <= rin - din;
          u_q[k] <= uin | UW'(1);
        end else begin
          r_q[k] <= rin;
          u_q[k] <= uin;
        end
      end
    end
  end

  assign vld_o    = v_q[NS-1];
  assign hit_o    = h_q[NS-1];
  assign status_o = st_q[NS-1];
  assign u_o      = u_q[NS-1];
  assign sx_o = sx_q[NS-1];
  assign sy_o = sy_q[NS-1];
  assign sz_o = sz_q[NS-1];
  assign dx_o = dx_q[NS-1];
  assign dy_o = dy_q[NS-1];
  assign dz_o = dz_q[NS-1];
endmodule

// ===== rtl/spi_scale.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_scale
// hit point: multiply stage, then floor shift and add stage
// ----------------------------------------------------------------------------
module spi_scale (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              adv_i,
  input  logic                              vld_i,
  input  logic                              hit_i,
  input  spi_pkg::status_e                  status_i,
  input  logic [spi_pkg::UW-1:0]            u_i,
  input  logic signed [spi_pkg::CoordW-1:0] sx_i, sy_i, sz_i,
  input  logic signed [spi_pkg::DiffW-1:0]  dx_i, dy_i, dz_i,
  output logic                              vld_o,
  output spi_pkg::res_t                     res_o
);
  localparam int MW = spi_pkg::DiffW + spi_pkg::UW + 1;
  localparam int CW = spi_pkg::CoordW;
  localparam int FW = spi_pkg::FracW;

  logic v1_q, v2_q, h1_q;
  spi_pkg::status_e st1_q;
  logic [spi_pkg::UW-1:0] u1_q;
  logic signed [CW-1:0] s1x_q, s1y_q, s1z_q;
  logic signed [MW-1:0] mx_q, my_q, mz_q;
  logic signed [MW-1:0] ux;

  assign ux = MW'({1'b0, u_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= vld_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      h1_q  <= hit_i;
      st1_q <= status_i;
      u1_q  <= u_i;
      s1x_q <= sx_i; s1y_q <= sy_i; s1z_q <= sz_i;
      mx_q <= MW'(dx_i) * ux;
      my_q <= MW'(dy_i) * ux;
      mz_q <= MW'(dz_i) * ux;
      // arithmetic shift gives floor toward minus infinity
      res_o.status  <= st1_q;
      res_o.param_u <= h1_q ? u1_q : '0;
      res_o.hit_x   <= h1_q ? s1x_q + CW'(mx_q >>> FW) : '0;
      res_o.hit_y   <= h1_q ? s1y_q + CW'(my_q >>> FW) : '0;
      res_o.hit_z   <= h1_q ? s1z_q + CW'(mz_q >>> FW) : '0;
    end
  end

  assign vld_o = v2_q;
endmodule

// ===== rtl/segment_plane_intersect_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_plane_intersect_top
// segment against configured plane intersection, fully pipelined
// ----------------------------------------------------------------------------
// pipeline: 3 front, 17 divider and 2 scale stages from item accept to result valid
// throughput: one item per cycle; the whole pipeline holds while the output stalls
// the divider takes one quotient bit per stage and sets the depth
// reset: pipeline empty, plane point zero, normal (0, 0, 1.0)
module segment_plane_intersect_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  spi_stream_if.sink                        seg_in,
  spi_stream_if.source                      res_out,
  input  logic                              cfg_we_i,
  input  logic [spi_pkg::IdxW-1:0]          cfg_idx_i,
  input  logic [spi_pkg::CoordW-1:0]        cfg_data_i
);
  spi_pkg::plane_t  plane_q;
  logic             adv, fv, fh, dvv, dh;
  spi_pkg::status_e fst, dst;
  logic [spi_pkg::DotW-1:0] anw, andv;
  logic [spi_pkg::UW-1:0]   u;
  logic signed [spi_pkg::CoordW-1:0] fsx, fsy, fsz, dsx, dsy, dsz;
  logic signed [spi_pkg::DiffW-1:0]  fdx, fdy, fdz, ddx, ddy, ddz;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_q <= spi_pkg::plane_t'{nz: spi_pkg::CoordW'(1) << spi_pkg::FracW, default: '0};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        spi_pkg::REG_PX: plane_q.px <= cfg_data_i;
        spi_pkg::REG_PY: plane_q.py <= cfg_data_i;
        spi_pkg::REG_PZ: plane_q.pz <= cfg_data_i;
        spi_pkg::REG_NX: plane_q.nx <= cfg_data_i;
        spi_pkg::REG_NY: plane_q.ny <= cfg_data_i;
        spi_pkg::REG_NZ: plane_q.nz <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // whole pipeline advances unless the output holds a pending item
  assign adv = !res_out.valid || res_out.ready;
  assign seg_in.ready = adv;

  spi_front u_front (
    .clk_i, .rst_ni, .adv_i(adv), .vld_i(seg_in.valid), .seg_i(seg_in.data),
    .plane_i(plane_q), .vld_o(fv), .hit_o(fh), .status_o(fst),
    .anw_o(anw), .and_o(andv), .sx_o(fsx), .sy_o(fsy), .sz_o(fsz),
    .dx_o(fdx), .dy_o(fdy), .dz_o(fdz)
  );

  spi_divider u_div (
    .clk_i, .rst_ni, .adv_i(adv), .vld_i(fv), .hit_i(fh), .status_i(fst),
    .anw_i(anw), .and_i(andv), .sx_i(fsx), .sy_i(fsy), .sz_i(fsz),
    .dx_i(fdx), .dy_i(fdy), .dz_i(fdz), .vld_o(dvv), .hit_o(dh),
    .status_o(dst), .u_o(u), .sx_o(dsx), .sy_o(dsy), .sz_o(dsz),
    .dx_o(ddx), .dy_o(ddy), .dz_o(ddz)
  );

  spi_scale u_scale (
    .clk_i, .rst_ni, .adv_i(adv), .vld_i(dvv), .hit_i(dh), .status_i(dst),
    .u_i(u), .sx_i(dsx), .sy_i(dsy), .sz_i(dsz),
    .dx_i(ddx), .dy_i(ddy), .dz_i(ddz), .vld_o(res_out.valid), .res_o(res_out.data)
  );

`ifndef SYNTH
  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_out.valid && !res_out.ready |=> res_out.valid && $stable(res_out.data))
    else $error("result changed under stall");
  // non-hit results carry zero payload
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_out.valid && res_out.data.status != spi_pkg::ST_HIT |->
    res_out.data.param_u == '0 && res_out.data.hit_x == '0)
    else $error("payload on non-hit");
  // u never exceeds one
  a_urange: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_out.valid |-> res_out.data.param_u <= (spi_pkg::UW'(1) << spi_pkg::FracW))
    else $error("u out of range");
`endif
endmodule
